### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/sxpk_pkg.sv
// Package with the constants and types of the SysEx seven-bit packer.
`timescale 1ns / 1ps

package sxpk_pkg;

	localparam int          MAX_FRAME_BYTES = 256;
	localparam int          LEN_W           = 9;
	localparam logic [7:0]  START_BYTE      = 8'hF0;
	localparam logic [7:0]  END_BYTE        = 8'hF7;
	localparam logic [6:0]  SEVEN_MASK      = 7'h7F;
	localparam logic [LEN_W-1:0] LIMIT_MIN  = 9'd3;
	localparam logic [LEN_W-1:0] LIMIT_MAX  = LEN_W'(MAX_FRAME_BYTES);
	localparam logic [LEN_W-1:0] CFG_RESET  = 9'd256;
	localparam int          MAX_RESULTS     = 4;

	// One coded result byte with its frame flags.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_done;
		logic       overflow;
	} res_t;

endpackage

### rtl/core/sysex_seven_bit_packer.sv
// Top level of the SysEx seven-bit packer: input register, packing logic, result buffer.
`timescale 1ns / 1ps

// Channel   Direction  Payload
// --------  ---------  --------------------------------------------------------
// s_axis    in         tdata = data_byte[7:0], tlast = frame_last
// m_axis    out        tdata = out_byte[7:0], tlast = run_last,
//                      tuser = {overflow, frame_done}
// cfg       in         cfg_data = max_frame_len[8:0], always ready
//
// Each input transfer occupies the output for as many results as it causes: one to four,
// one result per cycle while m_axis_tready is high, set by the single output port. An item
// dropped after an overflow passes the input register and gives no result.
// The next item is packed in the cycle the last result of the previous item is taken, so
// the output streams without gaps. A stall on m_axis holds the buffered results and, once
// the input register is full, deasserts s_axis_tready.
// Reset is asynchronous and clears the frame state, the buffer and the limit to 256.
module sysex_seven_bit_packer (
	input  logic                      clk,
	input  logic                      arst_n,
	// Input stream
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [7:0]                s_axis_tdata,   // [7:0] data_byte
	input  logic                      s_axis_tlast,   // frame_last
	// Output stream
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [7:0]                m_axis_tdata,   // [7:0] out_byte
	output logic                      m_axis_tlast,   // run_last
	output logic [1:0]                m_axis_tuser,   // [0] frame_done, [1] overflow
	// Configuration write channel
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [sxpk_pkg::LEN_W-1:0] cfg_data       // max_frame_len
);
	import sxpk_pkg::*;

	// Configuration register.
	logic [LEN_W-1:0] max_len_q;
	logic [LEN_W-1:0] lim;
	logic [LEN_W-1:0] lim_m1;

	// Input register.
	logic       v_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Frame state.
	logic [6:0]       carry_bits_q;
	logic [2:0]       carry_count_q;
	logic             in_frame_q;
	logic [LEN_W-1:0] emitted_q;
	logic             dropping_q;

	// Result buffer: the results of one item, read out one per cycle while m_axis_tready is high.
	res_t       buf_q [MAX_RESULTS];
	logic [2:0] buf_cnt_q;
	logic [1:0] rd_idx_q;

	logic buf_free;
	logic proc;
	logic out_xfer;
	logic at_last;

	// Packing logic outputs.
	res_t             res [MAX_RESULTS];
	logic [2:0]       n;
	logic [6:0]       nxt_bits;
	logic [2:0]       nxt_count;
	logic             nxt_in_frame;
	logic [LEN_W-1:0] nxt_emitted;
	logic             nxt_dropping;

	assign cfg_ready = 1'b1;

	// The effective limit is the register clamped to the legal range.
	always_comb begin
		if (max_len_q < LIMIT_MIN) begin
			lim = LIMIT_MIN;
		end else if (max_len_q > LIMIT_MAX) begin
			lim = LIMIT_MAX;
		end else begin
			lim = max_len_q;
		end
		lim_m1 = lim - LEN_W'(1);
	end

	// Handshake and buffer control.
	assign out_xfer      = m_axis_tvalid && m_axis_tready;
	assign at_last       = ({1'b0, rd_idx_q} == (buf_cnt_q - 3'd1));
	assign buf_free      = (buf_cnt_q == 3'd0) || (out_xfer && at_last);
	assign proc          = v_s1 && buf_free;
	assign s_axis_tready = !v_s1 || buf_free;

	assign m_axis_tvalid   = (buf_cnt_q != 3'd0);
	assign m_axis_tdata    = buf_q[rd_idx_q].out_byte;
	assign m_axis_tlast    = at_last;
	assign m_axis_tuser[0] = buf_q[rd_idx_q].frame_done;
	assign m_axis_tuser[1] = buf_q[rd_idx_q].overflow;

	// Packing of one item: optional start byte, one or two seven-bit groups, and on the
	// last byte the flush of leftover bits and the end byte. The limit check before each
	// data byte turns it into the overflow marker, after which nothing more is emitted.
	always_comb begin
		logic [14:0]      acc;
		logic [3:0]       bits;
		logic             ok;
		logic [LEN_W-1:0] cnt;
		logic [6:0]       cb;
		logic [2:0]       cc;

		for (int i = 0; i < MAX_RESULTS; i++) begin
			res[i] = '0;
		end
		n            = 3'd0;
		ok           = 1'b1;
		cnt          = emitted_q;
		cb           = carry_bits_q;
		cc           = carry_count_q;
		acc          = '0;
		bits         = '0;
		nxt_bits     = carry_bits_q;
		nxt_count    = carry_count_q;
		nxt_in_frame = in_frame_q;
		nxt_emitted  = emitted_q;
		nxt_dropping = dropping_q;

		if (in_frame_q && dropping_q) begin
			// Abandoned frame: swallow items until the closing one.
			if (last_s1) begin
				nxt_bits     = '0;
				nxt_count    = '0;
				nxt_in_frame = 1'b0;
				nxt_emitted  = '0;
				nxt_dropping = 1'b0;
			end
		end else begin
			if (!in_frame_q) begin
				res[0] = '{out_byte: START_BYTE, frame_done: 1'b0, overflow: 1'b0};
				n      = 3'd1;
				cnt    = LEN_W'(1);
				cb     = '0;
				cc     = '0;
			end

			acc  = {8'b0, cb} | ({7'b0, byte_s1} << cc);
			bits = {1'b0, cc} + 4'd8;

			// First group always exists.
			if (cnt >= lim_m1) begin
				res[n[1:0]] = '{out_byte: END_BYTE, frame_done: 1'b1, overflow: 1'b1};
				ok          = 1'b0;
			end else begin
				res[n[1:0]] = '{out_byte: {1'b0, acc[6:0] & SEVEN_MASK},
					frame_done: 1'b0, overflow: 1'b0};
				cnt         = cnt + LEN_W'(1);
			end
			n = n + 3'd1;

			// Second group when six bits were carried in.
			if (ok && bits == 4'd14) begin
				if (cnt >= lim_m1) begin
					res[n[1:0]] = '{out_byte: END_BYTE, frame_done: 1'b1, overflow: 1'b1};
					ok          = 1'b0;
				end else begin
					res[n[1:0]] = '{out_byte: {1'b0, acc[13:7]},
						frame_done: 1'b0, overflow: 1'b0};
					cnt         = cnt + LEN_W'(1);
				end
				n = n + 3'd1;
			end

			if (ok) begin
				if (bits == 4'd14) begin
					cb = '0;
					cc = '0;
				end else begin
					cb = acc[13:7];
					cc = 3'(bits - 4'd7);
				end
				if (last_s1) begin
					// Flush the leftover bits, zero-padded at the top.
					if (cc != 3'd0) begin
						if (cnt >= lim_m1) begin
							res[n[1:0]] = '{out_byte: END_BYTE, frame_done: 1'b1,
								overflow: 1'b1};
							ok          = 1'b0;
						end else begin
							res[n[1:0]] = '{out_byte: {1'b0, cb}, frame_done: 1'b0,
								overflow: 1'b0};
							cnt         = cnt + LEN_W'(1);
						end
						n = n + 3'd1;
					end
					if (ok) begin
						res[n[1:0]] = '{out_byte: END_BYTE, frame_done: 1'b1, overflow: 1'b0};
						n           = n + 3'd1;
					end
				end
			end

			if (last_s1) begin
				// The frame closes on its last byte, with or without overflow.
				nxt_bits     = '0;
				nxt_count    = '0;
				nxt_in_frame = 1'b0;
				nxt_emitted  = '0;
				nxt_dropping = 1'b0;
			end else begin
				nxt_bits     = cb;
				nxt_count    = cc;
				nxt_in_frame = 1'b1;
				nxt_emitted  = cnt;
				nxt_dropping = !ok;
			end
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Frame state commits when an item is packed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_bits_q  <= '0;
			carry_count_q <= '0;
			in_frame_q    <= 1'b0;
			emitted_q     <= '0;
			dropping_q    <= 1'b0;
		end else if (proc) begin
			carry_bits_q  <= nxt_bits;
			carry_count_q <= nxt_count;
			in_frame_q    <= nxt_in_frame;
			emitted_q     <= nxt_emitted;
			dropping_q    <= nxt_dropping;
		end
	end

	// Result buffer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_cnt_q <= '0;
			rd_idx_q  <= '0;
		end else if (proc) begin
			buf_cnt_q <= n;
			rd_idx_q  <= '0;
		end else if (out_xfer) begin
			if (at_last) begin
				buf_cnt_q <= '0;
				rd_idx_q  <= '0;
			end else begin
				rd_idx_q <= rd_idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				buf_q[i] <= res[i];
			end
		end
	end

endmodule

### rtl/core/sxpk_checker.sv
// Port-level checker for the SysEx seven-bit packer, with its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sxpk_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast,
	input logic [1:0] m_axis_tuser
);
	import sxpk_pkg::*;

	// A stalled result must hold still until it is taken.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

	// The overflow marker closes the frame, ends the item's results and reads as the end byte.
	`ASSERT_IMPLIES(a_ovf_marker, clk, arst_n, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0] && m_axis_tlast && (m_axis_tdata == END_BYTE))

	// Every frame close is the end byte and the last result of its item.
	`ASSERT_IMPLIES(a_close_end, clk, arst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast && (m_axis_tdata == END_BYTE))

	// Inside a frame only the start byte and seven-bit data appear.
	`ASSERT_IMPLIES(a_seven_bit, clk, arst_n, m_axis_tvalid && !m_axis_tuser[0] && (m_axis_tdata != START_BYTE), !m_axis_tdata[7] && !m_axis_tuser[1])

endmodule

bind sysex_seven_bit_packer sxpk_checker u_sxpk_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
